// ----- hdl/ept_pkg.sv -----
// Shared types, constants and field offsets of the encoder position/speed tracker.
// Used by every module of the block. No dependencies.
`timescale 1ns / 1ps

package ept_pkg;

    // Input function codes (carried on s_tuser)
    typedef enum logic [1:0] {
        FUNC_POSITION = 2'd0,
        FUNC_SPEED    = 2'd1,
        FUNC_FAULT    = 2'd2,
        FUNC_NONE     = 2'd3
    } func_t;

    // Register indexes (paddr[2])
    localparam logic REG_COUNTS_PER_REV = 1'b0;
    localparam logic REG_ZERO_OFFSET    = 1'b1;

    localparam int CPR_RESET = 4096;

    // 6e9 = 2^32 + SPEED_SCALE_LO
    localparam logic [31:0] SPEED_SCALE_LO = 32'h65A0_BC00;
    localparam logic [9:0]  MS_TO_US       = 10'd1000;
    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for any 32-bit x
    localparam logic [31:0] RECIP_100      = 32'h51EB_851F;
    localparam int          RECIP_SHIFT    = 37;
    localparam logic [7:0]  FAULT_LIMIT    = 8'd5;
    localparam logic [7:0]  TALLY_MAX      = 8'd255;

    localparam logic [63:0] SAT_NEG        = 64'h0000_0000_8000_0000;
    localparam logic [63:0] SAT_POS        = 64'h0000_0000_7FFF_FFFF;
    localparam logic [26:0] RPM_SAT_NEG    = 27'd32768;
    localparam logic [26:0] RPM_SAT_POS    = 27'd32767;

    // Serial divider widths
    localparam int NUM_W = 64;
    localparam int DEN_W = 48;
    localparam int STEP_W = $clog2(NUM_W);

    // Stream word widths
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 184;

    // Result word field offsets
    localparam int OFS_ACC      = 0;
    localparam int OFS_POS      = 32;
    localparam int OFS_SPEED    = 64;
    localparam int OFS_RPM      = 96;
    localparam int OFS_MAG      = 112;
    localparam int OFS_INTERVAL = 144;
    localparam int OFS_UPDATED  = 176;
    localparam int OFS_FAULT    = 177;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } div_rsp_t;

endpackage

// ----- hdl/ept_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, used by the speed path.
// Depends on ept_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module ept_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ept_pkg::div_req_t req,
    output ept_pkg::div_rsp_t rsp
);
    import ept_pkg::*;

    logic [DEN_W:0]    rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DEN_W:0]    shifted;
    logic [DEN_W+1:0]  diff;
    logic              fits;

    always_comb
    begin
        shifted = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        diff    = {1'b0, shifted} - {2'b00, den_reg};
        fits    = ~diff[DEN_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DEN_W:0] : shifted;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ----- hdl/encoder_position_speed_tracker.sv -----
// Encoder position and speed tracker: 32-bit count extension, position and
// M-method speed in hundredths of rpm. Depends on ept_pkg and ept_div.
`timescale 1ns / 1ps
// Usage
//   Input stream s_*: s_tuser selects the function (position sample, sample
//   plus speed update, fault check); s_tdata carries the counter sample, the
//   millisecond tick and the trigger flag. Output stream m_*: one result word
//   per input word, holding the extended count, position, speed values and
//   the fault flag. APB port: counts_per_rev at 0x0, zero_offset at 0x4.
//   Write configuration only while the block is idle.
// Flow and throughput
//   Position, fault and unused words go from accept to the done state. A
//   speed word stops at the interval state if no time elapsed, and passes
//   product, rpm and round over a zero interval or zero counts_per_rev;
//   else it runs setup, 64 one-bit divider steps, rpm, rounding and output.
//   One word is in work at a time; s_tready is high only when idle.
// Reset
//   rst_n clears all tracking state, sets counts_per_rev to 4096 and
//   zero_offset to 0, and empties the output register.
// Stall
//   A finished word waits in the output register while m_tready is low; the
//   block still accepts the next word and holds its result until the output
//   register frees up.

module encoder_position_speed_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] counter_sample, [47:16] tick_ms, [48] trigger_seen, [55:49] zero
    input  logic [ept_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] func
    input  logic [ept_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] accumulated_count, [63:32] position, [95:64] speed_centi_rpm,
    // [111:96] whole_rpm, [143:112] pulse_magnitude, [175:144] interval_us,
    // [176] speed_updated, [177] fault, [183:178] zero
    output logic [ept_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ept_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INTERVAL,
        ST_PRODUCT,
        ST_START,
        ST_DIVIDE,
        ST_RPM,
        ST_ROUND,
        ST_DONE
    } state_t;

    state_t        state_reg;

    logic [15:0]   cpr_reg;
    logic [31:0]   zero_offset_reg;

    logic [15:0]   last_sample_reg;
    logic [31:0]   ext_count_reg;
    logic [31:0]   count_last_reg;
    logic [31:0]   tick_last_reg;
    logic [31:0]   speed_reg;
    logic [15:0]   rpm_reg;
    logic [31:0]   mag_reg;
    logic [31:0]   interval_reg;
    logic [7:0]    tally_reg;
    logic          updated_reg;
    logic          neg_reg;
    logic          m_tvalid_reg;

    logic [31:0]   tick_in_reg;
    logic [47:0]   den_reg;
    logic [63:0]   prod_reg;
    logic [63:0]   rpm_prod_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic          accept;
    logic          cfg_write;
    logic          out_free;
    func_t         in_func;
    logic [15:0]   in_sample;
    logic          in_trigger;
    logic [15:0]   sample_diff;
    logic [31:0]   ext_count_next;
    logic [31:0]   elapsed;
    logic [41:0]   interval_full;
    logic [31:0]   delta;
    logic [31:0]   delta_mag;
    logic [63:0]   quo_sat;
    logic [31:0]   speed_next;
    logic [31:0]   speed_abs;
    logic [26:0]   rpm_whole;
    logic [15:0]   rpm_next;
    logic [31:0]   position;

    div_req_t      div_req;
    div_rsp_t      div_rsp;

    ept_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid & s_tready;
    assign cfg_write = psel & penable & pwrite;
    assign out_free  = ~m_tvalid_reg | m_tready;
    assign pready    = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        in_func        = func_t'(s_tuser);
        in_sample      = s_tdata[15:0];
        in_trigger     = s_tdata[48];
        sample_diff    = in_sample - last_sample_reg;
        ext_count_next = ext_count_reg + {{16{sample_diff[15]}}, sample_diff};

        elapsed        = tick_in_reg - tick_last_reg;
        interval_full  = 42'(elapsed) * 42'(MS_TO_US);
        delta          = ext_count_reg - count_last_reg;
        delta_mag      = delta[31] ? (~delta + 32'd1) : delta;

        // Saturate the quotient, then apply the sign
        if (neg_reg)
        begin
            quo_sat    = (div_rsp.quo > SAT_NEG) ? SAT_NEG : div_rsp.quo;
            speed_next = ~quo_sat[31:0] + 32'd1;
        end
        else
        begin
            quo_sat    = (div_rsp.quo > SAT_POS) ? SAT_POS : div_rsp.quo;
            speed_next = quo_sat[31:0];
        end

        speed_abs = speed_reg[31] ? (~speed_reg + 32'd1) : speed_reg;
        rpm_whole = rpm_prod_reg[63:RECIP_SHIFT];
        if (speed_reg[31])
        begin
            rpm_next = ~((rpm_whole > RPM_SAT_NEG) ? RPM_SAT_NEG[15:0] : rpm_whole[15:0])
                       + 16'd1;
        end
        else
        begin
            rpm_next = (rpm_whole > RPM_SAT_POS) ? RPM_SAT_POS[15:0] : rpm_whole[15:0];
        end

        position = ext_count_reg - zero_offset_reg;

        div_req.start = (state_reg == ST_START);
        div_req.num   = prod_reg + {mag_reg, 32'd0};
        div_req.den   = den_reg;
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_COUNTS_PER_REV: prdata = {16'd0, cpr_reg};
            REG_ZERO_OFFSET:    prdata = zero_offset_reg;
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg         <= 16'(CPR_RESET);
            zero_offset_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_COUNTS_PER_REV: cpr_reg         <= pwdata[15:0];
                REG_ZERO_OFFSET:    zero_offset_reg <= pwdata;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            last_sample_reg <= '0;
            ext_count_reg   <= '0;
            count_last_reg  <= '0;
            tick_last_reg   <= '0;
            speed_reg       <= '0;
            rpm_reg         <= '0;
            mag_reg         <= '0;
            interval_reg    <= '0;
            tally_reg       <= '0;
            updated_reg     <= 1'b0;
            neg_reg         <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
        end
        else
        begin
            // A word handed over in the done state is replaced there
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        updated_reg <= 1'b0;
                        state_reg   <= ST_DONE;
                        case (in_func)
                            FUNC_POSITION, FUNC_SPEED:
                            begin
                                last_sample_reg <= in_sample;
                                ext_count_reg   <= ext_count_next;
                                if (in_func == FUNC_SPEED)
                                begin
                                    state_reg <= ST_INTERVAL;
                                end
                            end
                            FUNC_FAULT:
                            begin
                                if (in_trigger && tally_reg != TALLY_MAX)
                                begin
                                    tally_reg <= tally_reg + 8'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_INTERVAL:
                begin
                    if (elapsed == 32'd0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        neg_reg        <= delta[31];
                        mag_reg        <= delta_mag;
                        interval_reg   <= interval_full[31:0];
                        count_last_reg <= ext_count_reg;
                        tick_last_reg  <= tick_in_reg;
                        updated_reg    <= 1'b1;
                        state_reg      <= ST_PRODUCT;
                    end
                end
                ST_PRODUCT:
                begin
                    // Zero interval or zero counts per rev reads as standstill
                    if (cpr_reg == 16'd0 || interval_reg == 32'd0)
                    begin
                        speed_reg <= '0;
                        state_reg <= ST_RPM;
                    end
                    else
                    begin
                        state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    if (div_rsp.done)
                    begin
                        speed_reg <= speed_next;
                        state_reg <= ST_RPM;
                    end
                end
                ST_RPM:
                begin
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    rpm_reg   <= rpm_next;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'd0, (tally_reg > FAULT_LIMIT), updated_reg,
                                         interval_reg, mag_reg, rpm_reg, speed_reg,
                                         position, ext_count_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tick_in_reg <= s_tdata[47:16];
        end
        if (state_reg == ST_PRODUCT)
        begin
            den_reg  <= 48'(cpr_reg) * 48'(interval_reg);
            prod_reg <= 64'(mag_reg) * 64'(SPEED_SCALE_LO);
        end
        if (state_reg == ST_RPM)
        begin
            rpm_prod_reg <= 64'(speed_abs) * 64'(RECIP_100);
        end
    end

endmodule

// ----- hdl/ept_checker.sv -----
// Port-level checks for the encoder position/speed tracker, bound to the top level.
// Depends on ept_pkg for the result word field offsets.
`timescale 1ns / 1ps

module ept_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [ept_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);
    import ept_pkg::*;

    // One word in work at a time: accept closes the input side
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a word was in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

    // An update over a wrapped-to-zero interval must report standstill
    a_zero_interval: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[OFS_UPDATED] && m_tdata[OFS_INTERVAL +: 32] == 32'd0)
        |-> (m_tdata[OFS_SPEED +: 32] == 32'd0))
        else $error("nonzero speed over zero interval");

    a_rpm_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[OFS_RPM + 15]) |-> m_tdata[OFS_SPEED + 31])
        else $error("whole rpm sign disagrees with speed");

endmodule

bind encoder_position_speed_tracker ept_checker u_ept_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ----- tb/encoder_position_speed_tracker_tb.sv -----
// Self-checking testbench for encoder_position_speed_tracker: stream and APB stimulus,
// a scoreboard class that predicts every result word. Depends on ept_pkg and the RTL.
`timescale 1ns / 1ps

module encoder_position_speed_tracker_tb;

    import ept_pkg::*;

    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned QUIET_LIMIT  = 5000;
    localparam int unsigned SETTLE_CYCLES = 200;

    // Result word fields, packed so that bit 0 is bit 0 of m_tdata
    typedef struct packed {
        logic        fault;
        logic        updated;
        logic [31:0] interval;
        logic [31:0] magnitude;
        logic [15:0] rpm;
        logic [31:0] centi_rpm;
        logic [31:0] position;
        logic [31:0] acc_count;
    } tracker_word_t;

    class tracker_scoreboard;
        logic [15:0]   counts_per_rev;
        logic [31:0]   zero_offset;
        logic [15:0]   last_sample;
        logic [31:0]   ext_count;
        logic [31:0]   count_at_speed;
        logic [31:0]   tick_at_speed;
        logic [31:0]   centi_rpm;
        logic [31:0]   magnitude;
        logic [31:0]   interval;
        logic [7:0]    fault_tally;
        tracker_word_t expected_words[$];
        int unsigned   mismatches;
        int unsigned   words_checked;

        function new();
            counts_per_rev = 16'(CPR_RESET);
            zero_offset    = '0;
            last_sample    = '0;
            ext_count      = '0;
            count_at_speed = '0;
            tick_at_speed  = '0;
            centi_rpm      = '0;
            magnitude      = '0;
            interval       = '0;
            fault_tally    = '0;
            mismatches     = 0;
            words_checked  = 0;
        endfunction

        function void set_register(logic reg_sel, logic [31:0] value);
            if (reg_sel == REG_COUNTS_PER_REV)
                counts_per_rev = value[15:0];
            else
                zero_offset = value;
        endfunction

        function void extend_count(logic [15:0] sample);
            logic [15:0] step;
            step        = sample - last_sample;
            ext_count   = ext_count + {{16{step[15]}}, step};
            last_sample = sample;
        endfunction

        function logic refresh_speed(logic [31:0] tick);
            logic [31:0] elapsed;
            logic [31:0] delta;
            logic [31:0] mag;
            logic [31:0] span;
            logic [63:0] quot;
            logic        neg;
            elapsed = tick - tick_at_speed;
            if (elapsed == 0)
                return 1'b0;
            delta     = ext_count - count_at_speed;
            neg       = delta[31];
            mag       = neg ? -delta : delta;
            span      = elapsed * 32'd1000;
            magnitude = mag;
            interval  = span;
            centi_rpm = '0;
            if (span != 0 && counts_per_rev != 0)
            begin
                quot = (64'(mag) * 64'd6000000000) / (64'(counts_per_rev) * 64'(span));
                if (neg)
                begin
                    if (quot > SAT_NEG)
                        quot = SAT_NEG;
                    centi_rpm = -quot[31:0];
                end
                else
                begin
                    if (quot > SAT_POS)
                        quot = SAT_POS;
                    centi_rpm = quot[31:0];
                end
            end
            count_at_speed = ext_count;
            tick_at_speed  = tick;
            return 1'b1;
        endfunction

        function logic [15:0] centi_to_rpm(logic [31:0] centi);
            logic        neg;
            logic [31:0] mag;
            logic [31:0] whole;
            neg   = centi[31];
            mag   = neg ? -centi : centi;
            whole = mag / 32'd100;
            if (neg)
            begin
                if (whole > 32'd32768)
                    whole = 32'd32768;
                return -whole[15:0];
            end
            if (whole > 32'd32767)
                whole = 32'd32767;
            return whole[15:0];
        endfunction

        function void note_input(func_t fn, logic [15:0] sample, logic [31:0] tick,
                                 logic trig);
            tracker_word_t w;
            logic          refreshed;
            refreshed = 1'b0;
            case (fn)
                FUNC_POSITION: extend_count(sample);
                FUNC_SPEED:
                begin
                    extend_count(sample);
                    refreshed = refresh_speed(tick);
                end
                FUNC_FAULT:
                begin
                    if (trig && fault_tally != TALLY_MAX)
                        fault_tally = fault_tally + 8'd1;
                end
                default: ;
            endcase
            w.acc_count = ext_count;
            w.position  = ext_count - zero_offset;
            w.centi_rpm = centi_rpm;
            w.rpm       = centi_to_rpm(centi_rpm);
            w.magnitude = magnitude;
            w.interval  = interval;
            w.updated   = refreshed;
            w.fault     = fault_tally > FAULT_LIMIT;
            expected_words.push_back(w);
        endfunction

        function string describe(tracker_word_t w);
            return $sformatf("acc %h pos %h centi %h rpm %h mag %h intv %h upd %b flt %b",
                             w.acc_count, w.position, w.centi_rpm, w.rpm, w.magnitude,
                             w.interval, w.updated, w.fault);
        endfunction

        function void check_result(tracker_word_t got);
            tracker_word_t want;
            string         bad;
            words_checked++;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result word %0d with nothing expected: %s",
                             words_checked, describe(got));
                return;
            end
            want = expected_words.pop_front();
            bad  = "";
            if (got.acc_count !== want.acc_count) bad = {bad, " accumulated_count"};
            if (got.position  !== want.position)  bad = {bad, " position"};
            if (got.centi_rpm !== want.centi_rpm) bad = {bad, " speed_centi_rpm"};
            if (got.rpm       !== want.rpm)       bad = {bad, " whole_rpm"};
            if (got.magnitude !== want.magnitude) bad = {bad, " pulse_magnitude"};
            if (got.interval  !== want.interval)  bad = {bad, " interval_us"};
            if (got.updated   !== want.updated)   bad = {bad, " speed_updated"};
            if (got.fault     !== want.fault)     bad = {bad, " fault"};
            if (bad != "")
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: result word %0d differs in%s", words_checked, bad);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [2:0]           paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    tracker_scoreboard sb = new();

    // Stimulus-side view of the shaft, used only to shape the random words
    logic [15:0] shaft_sample  = '0;
    logic [31:0] speed_tick    = '0;
    logic        steady        = 1'b0;
    logic        pressure_done = 1'b0;
    int unsigned pressure_mark = 32'hFFFF_FFFF;
    int unsigned quiet_cycles  = 0;

    encoder_position_speed_tracker u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    function automatic int unsigned pick_gap();
        if (steady || $urandom_range(0, 3) != 0)
            return 0;
        if ($urandom_range(0, 7) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_word(input func_t fn, input logic [15:0] sample,
                             input logic [31:0] tick, input logic trig);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {7'b0, trig, tick, sample};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(fn, sample, tick, trig);
        if (fn == FUNC_POSITION || fn == FUNC_SPEED)
            shaft_sample = sample;
        if (fn == FUNC_SPEED)
            speed_tick = tick;
    endtask

    // Drop valid and hold until every expected word has come back
    task automatic await_results();
        s_tvalid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(reg_sel, value);
    endtask

    task automatic write_config(input logic [15:0] cpr, input logic [31:0] offset);
        await_results();
        write_register(REG_COUNTS_PER_REV, {16'b0, cpr});
        write_register(REG_ZERO_OFFSET, offset);
    endtask

    initial
    begin : result_sink
        int unsigned idle_left;
        int unsigned hold_left;
        idle_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(tracker_word_t'(m_tdata[OFS_FAULT:0]));
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!pressure_done && sb.words_checked >= pressure_mark)
            begin
                // long hold-off: let the block fill up and stall its input
                pressure_done = 1'b1;
                hold_left     = HOLD_CYCLES - 1;
                m_tready     <= 1'b0;
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                idle_left = pick_gap();
                if (idle_left > 0)
                begin
                    idle_left--;
                    m_tready <= 1'b0;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("encoder_position_speed_tracker test failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        func_t       fn;
        logic [15:0] smp;
        logic [15:0] cpr;
        logic [31:0] tk;
        logic [31:0] offset;
        int unsigned pick;
        int unsigned counted;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words, reset configuration
        send_word(FUNC_POSITION, 16'h0000, 32'h0000_0000, 1'b0);
        send_word(FUNC_POSITION, 16'h7FFF, 32'hFFFF_FFFF, 1'b1);  // largest forward step
        send_word(FUNC_POSITION, 16'hFFFF, 32'h0000_0000, 1'b0);  // largest backward step
        send_word(FUNC_SPEED, 16'hFFFF, 32'h0000_0000, 1'b0);     // no time passed
        send_word(FUNC_SPEED, 16'h0100, 32'h0000_0001, 1'b0);
        send_word(FUNC_FAULT, 16'hABCD, 32'h5555_AAAA, 1'b1);
        send_word(FUNC_FAULT, 16'h1234, 32'hAAAA_5555, 1'b0);
        send_word(FUNC_NONE, 16'h5678, 32'hFFFF_FFFF, 1'b1);
        send_word(FUNC_SPEED, 16'h2000, 32'h2000_0001, 1'b0);     // interval wraps to zero
        send_word(FUNC_SPEED, 16'hF000, 32'hFFFF_FFFF, 1'b0);
        send_word(FUNC_SPEED, 16'h7000, 32'h0000_0000, 1'b0);     // tick wraps, fast reverse
        write_config(16'd1, 32'h0000_0000);
        send_word(FUNC_SPEED, 16'h7400, 32'h0000_0001, 1'b0);     // saturate positive
        send_word(FUNC_SPEED, 16'h6000, 32'h0000_0002, 1'b0);     // saturate negative
        write_config(16'd0, 32'h8000_0000);
        send_word(FUNC_SPEED, 16'h6100, 32'h0000_0003, 1'b0);     // zero counts per rev
        send_word(FUNC_POSITION, 16'hFFFF, 32'h0000_0000, 1'b0);
        write_config(16'hFFFF, 32'h7FFF_FFFF);
        send_word(FUNC_SPEED, 16'h6200, 32'd1003, 1'b0);
        send_word(FUNC_POSITION, 16'h0000, 32'h0000_0000, 1'b0);

        // climb in the largest forward steps between two speed words
        write_config(16'(CPR_RESET), 32'h0000_0000);
        steady = 1'b1;
        send_word(FUNC_SPEED, shaft_sample, speed_tick + 32'd1, 1'b0);
        repeat (24)
            send_word(FUNC_POSITION, shaft_sample + 16'd32767, $urandom, 1'($urandom));
        send_word(FUNC_POSITION, shaft_sample + 16'd2, $urandom, 1'b0);
        send_word(FUNC_SPEED, shaft_sample, speed_tick + 32'd1, 1'b0);
        repeat (16)
            send_word(FUNC_POSITION, shaft_sample + 16'd32767, $urandom, 1'($urandom));
        steady = 1'b0;

        // random words in segments, each under its own configuration
        await_results();
        pressure_mark = sb.words_checked + 150;
        for (int seg = 0; seg < 8; seg++)
        begin
            pick = $urandom_range(0, 5);
            if (pick == 0)
                cpr = 16'd1;
            else if (pick == 1)
                cpr = 16'hFFFF;
            else if (pick == 2)
                cpr = 16'd0;
            else if (pick == 3)
                cpr = 16'(CPR_RESET);
            else
                cpr = 16'($urandom_range(1, 65535));
            pick = $urandom_range(0, 3);
            if (pick == 0)
                offset = 32'h8000_0000;
            else if (pick == 1)
                offset = 32'h7FFF_FFFF;
            else
                offset = $urandom;
            write_config(cpr, offset);
            steady  = ($urandom_range(0, 3) == 0);
            counted = 0;
            while (counted < 80)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 2)
                    fn = FUNC_NONE;
                else if (pick < 5)
                    fn = FUNC_FAULT;
                else if (pick < 12)
                    fn = FUNC_SPEED;
                else
                    fn = FUNC_POSITION;
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    smp = 16'($urandom);
                else if (pick == 1)
                    smp = shaft_sample + 16'h8000;
                else if (pick == 2)
                    smp = shaft_sample + 16'h7FFF;
                else
                    smp = shaft_sample + 16'($urandom_range(0, 4000)) - 16'd2000;
                pick = $urandom_range(0, 15);
                if (fn != FUNC_SPEED || pick == 1)
                    tk = $urandom;
                else if (pick == 0)
                    tk = speed_tick;
                else if (pick == 2)
                    tk = speed_tick + 32'h2000_0000 * $urandom_range(1, 7);
                else
                    tk = speed_tick + $urandom_range(1, 20);
                send_word(fn, smp, tk, 1'($urandom));
                if (fn != FUNC_NONE)
                    counted++;
            end
        end
        steady = 1'b0;

        // push the fault tally into saturation
        repeat (260)
            send_word(FUNC_FAULT, 16'($urandom), $urandom, 1'b1);
        send_word(FUNC_SPEED, shaft_sample + 16'd100, speed_tick + 32'd1, 1'b0);
        send_word(FUNC_FAULT, 16'($urandom), $urandom, 1'b0);

        await_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("encoder_position_speed_tracker test passed");
        else
            $display("encoder_position_speed_tracker test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/ept_pkg.sv
hdl/ept_div.sv
hdl/encoder_position_speed_tracker.sv
hdl/ept_checker.sv
tb/encoder_position_speed_tracker_tb.sv
